// File: rtl/core/mps_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the permutation swapper modules.
package mps_pkg;

	localparam int unsigned IDX_W  = 6;
	localparam int unsigned WGT_W  = 17;
	localparam int unsigned THR_W  = 16;
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned PROD_W = 2 * WGT_W;
	localparam int unsigned CMP_W  = PROD_W + THR_W;

	localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_IDENT = 2'd1,
		CMD_SWAP  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// Which of the four pair weights a proposal reads.
	typedef enum logic [1:0] {
		WSEL_J_PI = 2'd0,
		WSEL_I_PJ = 2'd1,
		WSEL_I_PI = 2'd2,
		WSEL_J_PJ = 2'd3
	} wsel_t;

	typedef struct packed {
		cmd_t              command;
		logic [IDX_W-1:0]  first_index;
		logic [IDX_W-1:0]  second_index;
		logic [WGT_W-1:0]  weight_value;
		logic [THR_W-1:0]  random_threshold;
	} in_word_t;

	typedef struct packed {
		logic              status;
		logic              accepted;
		logic [IDX_W-1:0]  entry_value;
	} out_word_t;

	typedef struct packed {
		logic  latch;
		logic  perm_rd;
		logic  wt_we;
		wsel_t wt_sel;
		logic  cap_en;
		wsel_t cap_sel;
		logic  mul_num;
		logic  mul_den;
		logic  mul_thr;
		logic  cmp_en;
		logic  swap_i;
		logic  swap_j;
		logic  clr_en;
		logic  out_load;
	} dp_ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic pair_ok;
		logic clr_last;
		logic gt;
		logic out_free;
	} dp_sts_t;

endpackage

// File: rtl/core/mps_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the permutation swapper: steps each word through its commands.
module mps_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  mps_pkg::dp_sts_t sts,
	output mps_pkg::dp_ctl_t ctl
);
	import mps_pkg::*;

	typedef enum logic [12:0] {
		S_INIT  = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_PREAD = 13'b0000000000100,
		S_CLEAR = 13'b0000000001000,
		S_WRD0  = 13'b0000000010000,
		S_WRD1  = 13'b0000000100000,
		S_WRD2  = 13'b0000001000000,
		S_WRD3  = 13'b0000010000000,
		S_MUL0  = 13'b0000100000000,
		S_MUL1  = 13'b0001000000000,
		S_CMP   = 13'b0010000000000,
		S_SWAP0 = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   swap_second_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			swap_second_q <= 1'b0;
		end else begin
			state_q       <= state_d;
			swap_second_q <= (state_q == S_SWAP0) && !swap_second_q;
		end
	end

	always_comb begin
		ctl      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			S_INIT: begin
				ctl.clr_en = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.latch = 1'b1;
					state_d   = S_PREAD;
				end
			end
			S_PREAD: begin
				ctl.perm_rd = 1'b1;
				unique case (sts.cmd)
					CMD_LOAD: begin
						ctl.wt_we = sts.pair_ok;
						state_d   = S_DONE;
					end
					CMD_IDENT: state_d = S_CLEAR;
					CMD_SWAP:  state_d = sts.pair_ok ? S_WRD0 : S_DONE;
					CMD_READ:  state_d = S_DONE;
					default:   state_d = S_DONE;
				endcase
			end
			S_CLEAR: begin
				ctl.clr_en = 1'b1;
				if (sts.clr_last) state_d = S_DONE;
			end
			S_WRD0: begin
				ctl.wt_sel = WSEL_J_PI;
				state_d    = S_WRD1;
			end
			// Each read lands in the cycle after its address, so the capture trails.
			S_WRD1: begin
				ctl.wt_sel  = WSEL_I_PJ;
				ctl.cap_en  = 1'b1;
				ctl.cap_sel = WSEL_J_PI;
				state_d     = S_WRD2;
			end
			S_WRD2: begin
				ctl.wt_sel  = WSEL_I_PI;
				ctl.cap_en  = 1'b1;
				ctl.cap_sel = WSEL_I_PJ;
				state_d     = S_WRD3;
			end
			S_WRD3: begin
				ctl.wt_sel  = WSEL_J_PJ;
				ctl.cap_en  = 1'b1;
				ctl.cap_sel = WSEL_I_PI;
				ctl.mul_num = 1'b1;
				state_d     = S_MUL0;
			end
			S_MUL0: begin
				ctl.mul_den = 1'b1;
				state_d     = S_MUL1;
			end
			S_MUL1: begin
				ctl.mul_thr = 1'b1;
				state_d     = S_CMP;
			end
			S_CMP: begin
				ctl.cmp_en = 1'b1;
				state_d    = sts.gt ? S_SWAP0 : S_DONE;
			end
			// The permutation has one write port: entry i first, then entry j.
			S_SWAP0: begin
				if (swap_second_q) begin
					ctl.swap_j = 1'b1;
					state_d    = S_DONE;
				end else begin
					ctl.swap_i = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: rtl/core/mps_datapath.sv
`timescale 1ns / 1ps
// Datapath of the permutation swapper: item registers, memories, multiplier, result register.
module mps_datapath #(
	parameter int unsigned MAX_PARTICLES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mps_pkg::CNT_W-1:0]    cfg_wdata,
	input  mps_pkg::in_word_t            in_data,
	input  logic                         out_stall,
	output logic                         out_valid,
	output mps_pkg::out_word_t           out_data,
	input  mps_pkg::dp_ctl_t             ctl,
	output mps_pkg::dp_sts_t             sts
);
	import mps_pkg::*;

	localparam int unsigned PW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int unsigned DEPTH = MAX_PARTICLES * MAX_PARTICLES;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned XW    = PW + IDX_W;
	localparam logic [PW-1:0] LAST       = PW'(MAX_PARTICLES - 1);
	localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_PARTICLES);

	function automatic logic [PW-1:0] to_pidx(input logic [IDX_W-1:0] v);
		logic [XW-1:0] t;
		t = XW'(v);
		return t[PW-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] to_field(input logic [PW-1:0] v);
		logic [XW-1:0] t;
		t = XW'(v);
		return t[IDX_W-1:0];
	endfunction

	function automatic logic [AW-1:0] wt_addr(input logic [PW-1:0] row,
			input logic [PW-1:0] col);
		return AW'(AW'(row) * ROW_STRIDE + AW'(col));
	endfunction

	// Item registers
	cmd_t              cmd_q;
	logic [IDX_W-1:0]  i_q, j_q;
	logic [WGT_W-1:0]  w_q;
	logic [THR_W-1:0]  r_q;

	logic [CNT_W-1:0]  count_q;
	logic [PW-1:0]     clr_q;
	logic              acc_q;
	logic              out_valid_q;
	out_word_t         out_q;

	logic [PW-1:0]     pi_q, pj_q;
	logic [WGT_W-1:0]  wrd_q, wa_q, wb_q, wc_q;
	logic [PROD_W-1:0] num_q, den_q;
	logic [CMP_W-1:0]  prod_q;

	logic [PW-1:0]     i_idx, j_idx;
	logic              i_ok, j_ok, pair_ok, gt;
	logic              perm_we;
	logic [PW-1:0]     perm_waddr, perm_wdata;
	logic [AW-1:0]     wt_raddr, wt_waddr;
	out_word_t         res;

	logic [PW-1:0]     perm_mem [MAX_PARTICLES];
	logic [WGT_W-1:0]  wt_mem [DEPTH];

	assign i_idx   = to_pidx(i_q);
	assign j_idx   = to_pidx(j_q);
	// An index is in range below both the configured count and the store depth.
	assign i_ok    = ({1'b0, i_q} < count_q) && (32'(i_q) < MAX_PARTICLES);
	assign j_ok    = ({1'b0, j_q} < count_q) && (32'(j_q) < MAX_PARTICLES);
	assign pair_ok = i_ok && j_ok;
	assign gt      = {num_q, {THR_W{1'b0}}} > prod_q;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= in_data.command;
			i_q   <= in_data.first_index;
			j_q   <= in_data.second_index;
			w_q   <= in_data.weight_value;
			r_q   <= in_data.random_threshold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= COUNT_RESET;
			clr_q       <= '0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			if (ctl.clr_en) clr_q <= (clr_q == LAST) ? '0 : PW'(clr_q + 1'b1);
			if (ctl.latch) acc_q <= 1'b0;
			else if (ctl.cmp_en) acc_q <= gt;
			if (ctl.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Permutation store: the identity sweep and the two swap writes share one port.
	always_comb begin
		perm_we = ctl.clr_en | ctl.swap_i | ctl.swap_j;
		priority if (ctl.clr_en) begin
			perm_waddr = clr_q;
			perm_wdata = clr_q;
		end else if (ctl.swap_i) begin
			perm_waddr = i_idx;
			perm_wdata = pj_q;
		end else begin
			perm_waddr = j_idx;
			perm_wdata = pi_q;
		end
	end

	always_ff @(posedge clk) begin
		if (perm_we) perm_mem[perm_waddr] <= perm_wdata;
		if (ctl.perm_rd) begin
			pi_q <= perm_mem[i_idx];
			pj_q <= perm_mem[j_idx];
		end
	end

	// Weight table: row-major, one write port and one registered read port.
	always_comb begin
		wt_waddr = wt_addr(i_idx, j_idx);
		unique case (ctl.wt_sel)
			WSEL_J_PI: wt_raddr = wt_addr(j_idx, pi_q);
			WSEL_I_PJ: wt_raddr = wt_addr(i_idx, pj_q);
			WSEL_I_PI: wt_raddr = wt_addr(i_idx, pi_q);
			WSEL_J_PJ: wt_raddr = wt_addr(j_idx, pj_q);
			default:   wt_raddr = wt_addr(j_idx, pi_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.wt_we) wt_mem[wt_waddr] <= w_q;
		wrd_q <= wt_mem[wt_raddr];
	end

	// Acceptance test num * 2^16 > threshold * den, one product per cycle.
	always_ff @(posedge clk) begin
		if (ctl.cap_en) begin
			unique case (ctl.cap_sel)
				WSEL_J_PI: wa_q <= wrd_q;
				WSEL_I_PJ: wb_q <= wrd_q;
				WSEL_I_PI: wc_q <= wrd_q;
				default: begin
				end
			endcase
		end
		if (ctl.mul_num) num_q <= PROD_W'(wa_q) * PROD_W'(wb_q);
		if (ctl.mul_den) den_q <= PROD_W'(wc_q) * PROD_W'(wrd_q);
		if (ctl.mul_thr) prod_q <= CMP_W'(r_q) * CMP_W'(den_q);
	end

	always_comb begin
		res.accepted = acc_q;
		unique case (cmd_q)
			CMD_LOAD:  res.status = !pair_ok;
			CMD_IDENT: res.status = 1'b0;
			CMD_SWAP:  res.status = !pair_ok;
			CMD_READ:  res.status = !i_ok;
			default:   res.status = 1'b0;
		endcase
		priority if (!i_ok) res.entry_value = '0;
		else if (cmd_q == CMD_IDENT) res.entry_value = i_q;
		else if (acc_q) res.entry_value = to_field(pj_q);
		else res.entry_value = to_field(pi_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) out_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.cmd      = cmd_q;
	assign sts.pair_ok  = pair_ok;
	assign sts.clr_last = (clr_q == LAST);
	assign sts.gt       = gt;
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

// File: rtl/core/metropolis_permutation_swapper.sv
`timescale 1ns / 1ps
// Permutation swapper top level: keeps a particle permutation and pair weights.
//
// Input channel in_valid/in_stall/in_data carries one command word; the output
// channel out_valid/out_stall/out_data returns exactly one result word for it.
// A word is taken at a clock edge with valid high and stall low. The particle
// count register is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. One word is
// processed at a time. A load, a read and a word with a rejected index go
// straight from the permutation read to the result; an identity reset sweeps
// one store entry per cycle; a swap proposal reads and compares its weights and
// writes both permutation entries only if it is carried out.
// A proposal is bounded by the weight table's single read port (four reads),
// three products formed one per cycle, and the single write port of the
// permutation store. The output register holds a finished word, so a new word
// is accepted while the previous result is stalled; the block then waits at its
// last step until that register frees.
// After reset the permutation store is swept back to identity with in_stall high;
// the particle count resets to 64.
module metropolis_permutation_swapper #(
	parameter int unsigned MAX_PARTICLES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mps_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  mps_pkg::in_word_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output mps_pkg::out_word_t         out_data
);
	import mps_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	mps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	mps_datapath #(
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule

// File: rtl/core/mps_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the permutation swapper, bound to its top level.
module mps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input mps_pkg::out_word_t out_data
);
	import mps_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result word changed while stalled");

	// Words are processed one at a time, so an accept is never followed by another.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word accepted while one is in progress");

	a_swap_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.accepted && out_data.status))
		else $error("swap reported as carried out on an index error");

endmodule

bind metropolis_permutation_swapper mps_checker u_mps_checker (.*);

// File: tb/metropolis_permutation_swapper_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Metropolis permutation swapper.
module metropolis_permutation_swapper_tb;
	import mps_pkg::*;

	localparam int PARTICLES    = 64;
	localparam int SETTLE_WAIT  = PARTICLES + 16;
	localparam int CYCLE_LIMIT  = 1_000_000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CNT_W-1:0]   cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_word_t           in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_word_t          out_data;

	// Shadow copy of the block state, advanced as each word is accepted.
	logic [IDX_W-1:0]   perm_model [PARTICLES];
	logic [WGT_W-1:0]   weight_model [PARTICLES * PARTICLES];
	bit                 weight_loaded [PARTICLES * PARTICLES];
	logic [CNT_W-1:0]   count_model;

	out_word_t          pending_result_words [$];
	out_word_t          oldest_word;
	int                 words_sent = 0;
	int                 mismatch_count = 0;
	int                 cycle_count = 0;
	int                 sender_gap_pct = 34;
	int                 sink_stall_pct = 65;

	metropolis_permutation_swapper #(.MAX_PARTICLES(PARTICLES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("metropolis_permutation_swapper test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_result_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word: status %0b accepted %0b entry %0d",
						out_data.status, out_data.accepted, out_data.entry_value);
			end else begin
				oldest_word = pending_result_words.pop_front();
				if (out_data.status !== oldest_word.status ||
						out_data.accepted !== oldest_word.accepted ||
						out_data.entry_value !== oldest_word.entry_value) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected status %0b accepted %0b entry %0d, ",
							oldest_word.status, oldest_word.accepted,
							oldest_word.entry_value,
							"got status %0b accepted %0b entry %0d",
							out_data.status, out_data.accepted, out_data.entry_value);
				end
			end
		end
	end

	function automatic int active_particles();
		return (count_model > PARTICLES) ? PARTICLES : int'(count_model);
	endfunction

	function automatic int slot(input int row, input int col);
		return row * PARTICLES + col;
	endfunction

	// Applies one command word to the shadow state and returns its result word.
	function automatic out_word_t compute_result_word(input in_word_t w);
		out_word_t        r;
		int               n;
		bit               i_ok;
		bit               j_ok;
		logic [IDX_W-1:0] pi;
		logic [IDX_W-1:0] pj;
		bit [63:0]        num;
		bit [63:0]        den;
		bit [63:0]        thr;
		n = active_particles();
		i_ok = w.first_index < n;
		j_ok = w.second_index < n;
		r = '0;
		case (w.command)
			CMD_LOAD: begin
				if (i_ok && j_ok) begin
					weight_model[slot(w.first_index, w.second_index)] = w.weight_value;
					weight_loaded[slot(w.first_index, w.second_index)] = 1'b1;
				end else begin
					r.status = 1'b1;
				end
			end
			CMD_IDENT: begin
				for (int k = 0; k < PARTICLES; k++)
					perm_model[k] = 6'(k);
			end
			CMD_SWAP: begin
				if (i_ok && j_ok) begin
					pi = perm_model[w.first_index];
					pj = perm_model[w.second_index];
					num = 64'(weight_model[slot(w.second_index, pi)]) *
						64'(weight_model[slot(w.first_index, pj)]);
					den = 64'(weight_model[slot(w.first_index, pi)]) *
						64'(weight_model[slot(w.second_index, pj)]);
					thr = 64'(w.random_threshold);
					if ((num << THR_W) > thr * den) begin
						perm_model[w.first_index] = pj;
						perm_model[w.second_index] = pi;
						r.accepted = 1'b1;
					end
				end else begin
					r.status = 1'b1;
				end
			end
			default: begin
				if (!i_ok)
					r.status = 1'b1;
			end
		endcase
		r.entry_value = i_ok ? perm_model[w.first_index] : '0;
		return r;
	endfunction

	function automatic in_word_t make_word(input cmd_t c, input int i, input int j,
			input int wv, input int thr);
		in_word_t w;
		w.command = c;
		w.first_index = i[IDX_W-1:0];
		w.second_index = j[IDX_W-1:0];
		w.weight_value = wv[WGT_W-1:0];
		w.random_threshold = thr[THR_W-1:0];
		return w;
	endfunction

	function automatic int random_weight();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return 0;
		if (pick < 20)
			return 65536;
		return $urandom_range(1, 65536);
	endfunction

	function automatic int random_threshold();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return 0;
		if (pick < 20)
			return 65535;
		return $urandom_range(0, 65535);
	endfunction

	// True when all four weights a proposal of i and j would read are loaded.
	function automatic bit weights_ready(input int i, input int j);
		int pi;
		int pj;
		pi = perm_model[i];
		pj = perm_model[j];
		return weight_loaded[slot(j, pi)] && weight_loaded[slot(i, pj)] &&
			weight_loaded[slot(i, pi)] && weight_loaded[slot(j, pj)];
	endfunction

	// Called at a rising edge; returns at the edge that accepts the word.
	task automatic send_word(input in_word_t w);
		if ($urandom_range(0, 99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_gap_pct);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_result_words.push_back(compute_result_word(w));
		words_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_result_words.size() != 0)
			@(posedge clk);
		// Let the block settle before any configuration write.
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_particle_count(input logic [CNT_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_model = value;
	endtask

	// Loads whatever weights the proposal needs, then sends it. Gives up when a
	// needed weight sits in a column that the particle count does not allow.
	task automatic propose_swap(input int i, input int j, output bit done);
		int rows [4];
		int cols [4];
		int n;
		n = active_particles();
		rows = '{j, i, i, j};
		cols = '{int'(perm_model[i]), int'(perm_model[j]), int'(perm_model[i]),
			int'(perm_model[j])};
		done = 1'b0;
		foreach (rows[k])
			if (!weight_loaded[slot(rows[k], cols[k])] && cols[k] >= n)
				return;
		foreach (rows[k])
			if (!weight_loaded[slot(rows[k], cols[k])])
				send_word(make_word(CMD_LOAD, rows[k], cols[k], random_weight(),
					random_threshold()));
		send_word(make_word(CMD_SWAP, i, j, random_weight(), random_threshold()));
		done = 1'b1;
	endtask

	task automatic test_swap_decisions();
		send_word(make_word(CMD_READ, 63, 0, 0, 0));
		send_word(make_word(CMD_LOAD, 0, 0, 65536, 0));
		send_word(make_word(CMD_LOAD, 1, 1, 65536, 65535));
		send_word(make_word(CMD_LOAD, 0, 1, 65536, 0));
		send_word(make_word(CMD_LOAD, 1, 0, 65536, 0));
		// Ratio of one against the largest threshold.
		send_word(make_word(CMD_SWAP, 0, 1, 0, 65535));
		send_word(make_word(CMD_READ, 0, 63, 65536, 65535));
		send_word(make_word(CMD_SWAP, 0, 0, 0, 0));
		// Zero denominator with a nonzero numerator.
		send_word(make_word(CMD_LOAD, 1, 0, 0, 0));
		send_word(make_word(CMD_SWAP, 0, 1, 0, 65535));
		// Zero numerator, then zero over zero.
		send_word(make_word(CMD_SWAP, 0, 1, 0, 0));
		send_word(make_word(CMD_LOAD, 0, 0, 0, 0));
		send_word(make_word(CMD_SWAP, 0, 1, 0, 0));
		// A ratio of one half equal to the threshold is refused, just below it wins.
		send_word(make_word(CMD_LOAD, 0, 0, 65536, 0));
		send_word(make_word(CMD_LOAD, 1, 0, 32768, 0));
		send_word(make_word(CMD_SWAP, 0, 1, 0, 32768));
		send_word(make_word(CMD_SWAP, 0, 1, 0, 32767));
	endtask

	task automatic test_identity_reset();
		send_word(make_word(CMD_IDENT, 63, 63, 65536, 65535));
		send_word(make_word(CMD_READ, 1, 0, 0, 0));
	endtask

	task automatic test_index_limits();
		write_particle_count(7'd2);
		send_word(make_word(CMD_SWAP, 0, 5, 0, 0));
		send_word(make_word(CMD_LOAD, 5, 0, 65536, 0));
		send_word(make_word(CMD_READ, 5, 0, 0, 0));
		send_word(make_word(CMD_IDENT, 63, 0, 0, 0));
		write_particle_count(7'd0);
		send_word(make_word(CMD_READ, 0, 0, 0, 0));
		send_word(make_word(CMD_SWAP, 0, 0, 0, 0));
		write_particle_count(7'd127);
		send_word(make_word(CMD_READ, 63, 63, 0, 0));
		write_particle_count(7'd1);
		send_word(make_word(CMD_READ, 1, 0, 0, 0));
	endtask

	task automatic test_random_traffic(input int gap_pct, input int stall_pct,
			input logic [CNT_W-1:0] count, input int total);
		int       first_word;
		int       n;
		int       pick;
		int       i;
		int       j;
		bit       done;
		in_word_t w;
		write_particle_count(count);
		sender_gap_pct = gap_pct;
		sink_stall_pct = stall_pct;
		n = active_particles();
		first_word = words_sent;
		while (words_sent - first_word < total) begin
			pick = $urandom_range(0, 99);
			i = $urandom_range(0, n - 1);
			j = $urandom_range(0, n - 1);
			if (pick < 45) begin
				propose_swap(i, j, done);
				if (!done)
					send_word(make_word(CMD_IDENT, i, j, random_weight(), random_threshold()));
			end else if (pick < 60) begin
				send_word(make_word(CMD_LOAD, i, j, random_weight(), random_threshold()));
			end else if (pick < 75) begin
				send_word(make_word(CMD_READ, i, j, random_weight(), random_threshold()));
			end else if (pick < 79) begin
				send_word(make_word(CMD_IDENT, i, j, random_weight(), random_threshold()));
			end else begin
				w = make_word(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 65536),
					$urandom_range(0, 65535));
				// Never let a stray proposal read a weight that was never loaded.
				if (w.command == CMD_SWAP && w.first_index < n && w.second_index < n &&
						!weights_ready(w.first_index, w.second_index))
					w.command = CMD_READ;
				send_word(w);
			end
		end
	endtask

	initial begin
		for (int k = 0; k < PARTICLES; k++)
			perm_model[k] = 6'(k);
		count_model = COUNT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_swap_decisions();
		test_identity_reset();
		test_index_limits();
		test_random_traffic(34, 65, 7'd6, 600);
		test_random_traffic(65, 34, 7'd64, 600);
		test_random_traffic(0, 0, 7'd23, 600);
		wait_idle();
		if (mismatch_count == 0 && pending_result_words.size() == 0)
			$display("metropolis_permutation_swapper test passed");
		else
			$display("metropolis_permutation_swapper test failed");
		$finish;
	end

endmodule
